/* rtl/rsitt_pkg.sv */
// shared widths, register indexes and action codes for the rsi threshold trader
package rsitt_pkg;

  localparam int CASH_W     = 48;
  localparam int HOLD_W     = 9;
  localparam int LIMIT_W    = 8;
  localparam int LEVEL_W    = 15;
  localparam int WINLEN_W   = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // 100 percent in 1/256 percent units
  localparam logic [LEVEL_W-1:0] FULL_SCALE = 15'd25600;

  localparam logic [WINLEN_W-1:0] WINDOW_LEN_RST     = 9'd14;
  localparam logic [LIMIT_W-1:0]  POSITION_LIMIT_RST = 8'd5;
  localparam logic [LEVEL_W-1:0]  OVERSOLD_RST       = 15'd7680;
  localparam logic [LEVEL_W-1:0]  OVERBOUGHT_RST     = 15'd17920;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN     = 2'd0,
    REG_POSITION_LIMIT = 2'd1,
    REG_OVERSOLD       = 2'd2,
    REG_OVERBOUGHT     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_t;

endpackage

/* rtl/rsitt_trade.sv */
// threshold compare, position and cash update, mark to market and output register
module rsitt_trade
  import rsitt_pkg::*;
#(
  parameter int PRICE_BITS = 32,
  parameter int SUM_W      = 41
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  logic [PRICE_BITS-1:0]    req_price,
  input  logic [SUM_W-1:0]         req_gain,
  input  logic [SUM_W-1:0]         req_loss,
  input  logic [LIMIT_W-1:0]       position_limit,
  input  logic [LEVEL_W-1:0]       oversold_level,
  input  logic [LEVEL_W-1:0]       overbought_level,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_action,
  output logic signed [HOLD_W-1:0] out_holding,
  output logic signed [CASH_W-1:0] out_cash_balance,
  output logic signed [CASH_W-1:0] out_marked_profit
);

  localparam int TOT_W  = SUM_W + 1;
  localparam int PROD_W = TOT_W + LEVEL_W;
  localparam int CSUM_W = ((CASH_W > PRICE_BITS + 1) ? CASH_W : PRICE_BITS + 1) + 1;
  localparam int PM_W   = PRICE_BITS + 1 + HOLD_W;
  localparam int MARK_W = ((PM_W > CASH_W) ? PM_W : CASH_W) + 1;

  function automatic logic signed [CASH_W-1:0] sat_cash(input logic signed [CSUM_W-1:0] v);
    logic [CSUM_W-CASH_W:0] top;
    top = v[CSUM_W-1:CASH_W-1];
    if ((&top) || !(|top)) begin
      sat_cash = v[CASH_W-1:0];
    end else begin
      sat_cash = {v[CSUM_W-1], {(CASH_W-1){~v[CSUM_W-1]}}};
    end
  endfunction

  function automatic logic signed [CASH_W-1:0] sat_mark(input logic signed [MARK_W-1:0] v);
    logic [MARK_W-CASH_W:0] top;
    top = v[MARK_W-1:CASH_W-1];
    if ((&top) || !(|top)) begin
      sat_mark = v[CASH_W-1:0];
    end else begin
      sat_mark = {v[MARK_W-1], {(CASH_W-1){~v[MARK_W-1]}}};
    end
  endfunction

  // stage 1: total
  logic                  t1_valid_r;
  logic [PRICE_BITS-1:0] t1_price_r;
  logic [SUM_W-1:0]      t1_gain_r;
  logic [TOT_W-1:0]      t1_total_r;
  // stage 2: cross products
  logic                  t2_valid_r;
  logic [PRICE_BITS-1:0] t2_price_r;
  logic [PROD_W-1:0]     t2_pg_r;
  logic [PROD_W-1:0]     t2_plo_r;
  logic [PROD_W-1:0]     t2_phi_r;
  logic                  t2_nz_r;
  // stage 3: signals
  logic                  t3_valid_r;
  logic [PRICE_BITS-1:0] t3_price_r;
  logic                  t3_buy_r;
  logic                  t3_sell_r;
  // stage 4: trade applied
  logic                     t4_valid_r;
  logic [PRICE_BITS-1:0]    t4_price_r;
  action_t                  t4_action_r;
  logic signed [HOLD_W-1:0] t4_units_r;
  logic signed [CASH_W-1:0] t4_cash_r;
  // stage 5: holding times price
  logic                     t5_valid_r;
  action_t                  t5_action_r;
  logic signed [HOLD_W-1:0] t5_units_r;
  logic signed [CASH_W-1:0] t5_cash_r;
  logic signed [PM_W-1:0]   t5_pm_r;
  // output register
  logic                     out_valid_r;
  action_t                  out_action_r;
  logic signed [HOLD_W-1:0] out_units_r;
  logic signed [CASH_W-1:0] out_cash_r;
  logic signed [CASH_W-1:0] out_mark_r;

  // trading state
  logic signed [HOLD_W-1:0] units_r;
  logic signed [CASH_W-1:0] cash_r;

  logic rdy_o, rdy5, rdy4, rdy3, rdy2, rdy1;

  assign rdy_o     = !out_valid_r || !out_stall;
  assign rdy5      = !t5_valid_r || rdy_o;
  assign rdy4      = !t4_valid_r || rdy5;
  assign rdy3      = !t3_valid_r || rdy4;
  assign rdy2      = !t2_valid_r || rdy3;
  assign rdy1      = !t1_valid_r || rdy2;
  assign req_ready = rdy1;

  // buy first, then sell on the holding that the buy left
  logic signed [HOLD_W-1:0] lim;
  logic signed [HOLD_W-1:0] neg_lim;
  logic signed [CSUM_W-1:0] price_ext;
  logic signed [HOLD_W-1:0] units_a;
  logic signed [HOLD_W-1:0] units_nxt;
  logic signed [CASH_W-1:0] cash_a;
  logic signed [CASH_W-1:0] cash_nxt;
  logic                     buy_ok;
  logic                     sell_ok;
  action_t                  action_nxt;

  always_comb begin
    lim       = $signed({1'b0, position_limit});
    neg_lim   = -lim;
    price_ext = $signed({{(CSUM_W-PRICE_BITS){1'b0}}, t3_price_r});
    buy_ok    = t3_buy_r && (units_r < lim);
    units_a   = units_r;
    cash_a    = cash_r;
    if (buy_ok) begin
      units_a = units_r + HOLD_W'(1);
      cash_a  = sat_cash(CSUM_W'(cash_r) - price_ext);
    end
    sell_ok   = t3_sell_r && (units_a > neg_lim);
    units_nxt = units_a;
    cash_nxt  = cash_a;
    if (sell_ok) begin
      units_nxt = units_a - HOLD_W'(1);
      cash_nxt  = sat_cash(CSUM_W'(cash_a) + price_ext);
    end
    if (buy_ok && sell_ok) begin
      action_nxt = ACT_NONE;
    end else if (buy_ok) begin
      action_nxt = ACT_BUY;
    end else if (sell_ok) begin
      action_nxt = ACT_SELL;
    end else begin
      action_nxt = ACT_NONE;
    end
  end

  logic signed [PRICE_BITS:0]   price_s4;
  logic signed [MARK_W-1:0]     mark_sum;

  assign price_s4 = $signed({1'b0, t4_price_r});
  assign mark_sum = MARK_W'(t5_cash_r) + MARK_W'(t5_pm_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_valid_r  <= 1'b0;
      t2_valid_r  <= 1'b0;
      t3_valid_r  <= 1'b0;
      t4_valid_r  <= 1'b0;
      t5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      units_r     <= '0;
      cash_r      <= '0;
    end else begin
      if (rdy1) begin
        t1_valid_r <= req_valid;
        t1_price_r <= req_price;
        t1_gain_r  <= req_gain;
        t1_total_r <= TOT_W'(req_gain) + TOT_W'(req_loss);
      end
      if (rdy2) begin
        t2_valid_r <= t1_valid_r;
        t2_price_r <= t1_price_r;
        t2_pg_r    <= PROD_W'(t1_gain_r) * PROD_W'(FULL_SCALE);
        t2_plo_r   <= PROD_W'(t1_total_r) * PROD_W'(oversold_level);
        t2_phi_r   <= PROD_W'(t1_total_r) * PROD_W'(overbought_level);
        t2_nz_r    <= |t1_total_r;
      end
      if (rdy3) begin
        t3_valid_r <= t2_valid_r;
        t3_price_r <= t2_price_r;
        // no gain and no loss leaves the index undefined: no trade
        t3_buy_r   <= t2_nz_r && (t2_pg_r < t2_plo_r);
        t3_sell_r  <= t2_nz_r && (t2_pg_r > t2_phi_r);
      end
      if (rdy4) begin
        t4_valid_r  <= t3_valid_r;
        t4_price_r  <= t3_price_r;
        t4_action_r <= action_nxt;
        t4_units_r  <= units_nxt;
        t4_cash_r   <= cash_nxt;
        if (t3_valid_r) begin
          units_r <= units_nxt;
          cash_r  <= cash_nxt;
        end
      end
      if (rdy5) begin
        t5_valid_r  <= t4_valid_r;
        t5_action_r <= t4_action_r;
        t5_units_r  <= t4_units_r;
        t5_cash_r   <= t4_cash_r;
        t5_pm_r     <= PM_W'(t4_units_r) * PM_W'(price_s4);
      end
      if (rdy_o) begin
        out_valid_r  <= t5_valid_r;
        out_action_r <= t5_action_r;
        out_units_r  <= t5_units_r;
        out_cash_r   <= t5_cash_r;
        out_mark_r   <= sat_mark(mark_sum);
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = out_action_r;
  assign out_holding       = out_units_r;
  assign out_cash_balance  = out_cash_r;
  assign out_marked_profit = out_mark_r;

endmodule

/* rtl/rsi_threshold_trader_core.sv */
// rsi threshold trader: price change history memory, window sums and trade pipeline
//
// Input channel in_valid/in_stall/in_price carries one closing price per request.
// A request is taken at a clock edge with in_valid high and in_stall low. Every
// request after the first one of a window writes its price change into the history
// memory; once window_len changes are summed, each request yields one result on
// out_valid/out_stall: action, holding, cash balance and marked profit.
// Throughput is one request per cycle while out_stall is low. Each request passes
// the history memory read, the gain and loss sums, then total, cross products,
// compare, trade update, holding times price and the saturating output add.
// Requests in warm-up give no result. When the receiver stalls, the stages behind
// the output register keep filling, and in_stall rises only once the stage after
// the memory read is held. Configuration writes on cfg_we/cfg_index/cfg_data take
// effect at once; the user must make them only while the block is idle, which the
// block does not enforce. A window_len write restarts the window but keeps holding
// and cash. Reset (rst_n low, synchronous) loads the default registers, clears
// sums, counts, holding and cash. The history memory needs no clearing.
module rsi_threshold_trader_core
  import rsitt_pkg::*;
#(
  parameter int MAX_WINDOW = 256,
  parameter int PRICE_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [PRICE_BITS-1:0]    in_price,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_action,
  output logic signed [HOLD_W-1:0] out_holding,
  output logic signed [CASH_W-1:0] out_cash_balance,
  output logic signed [CASH_W-1:0] out_marked_profit,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W = $clog2(MAX_WINDOW + 2);
  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int ENT_W = PRICE_BITS + 1;
  localparam int SUM_W = PRICE_BITS + $clog2(MAX_WINDOW) + 1;

  // configuration
  logic [WINLEN_W-1:0] window_len_r;
  logic [LIMIT_W-1:0]  position_limit_r;
  logic [LEVEL_W-1:0]  oversold_r;
  logic [LEVEL_W-1:0]  overbought_r;

  // window state
  logic [PRICE_BITS-1:0] last_price_r;
  logic [CNT_W-1:0]      items_seen_r;
  logic [PTR_W-1:0]      ring_ptr_r;
  logic [SUM_W-1:0]      gain_sum_r;
  logic [SUM_W-1:0]      loss_sum_r;

  // history memory: {fall, magnitude}
  logic [ENT_W-1:0] hist_mem [MAX_WINDOW];
  logic [ENT_W-1:0] hist_rd_r;

  // stage after the memory read
  logic                  s1_valid_r;
  logic                  s1_emit_r;
  logic                  s1_sub_r;
  logic                  s1_neg_r;
  logic [PRICE_BITS-1:0] s1_mag_r;
  logic [PRICE_BITS-1:0] s1_price_r;

  // stage holding updated sums
  logic                  s2_valid_r;
  logic [PRICE_BITS-1:0] s2_price_r;
  logic [SUM_W-1:0]      s2_gain_r;
  logic [SUM_W-1:0]      s2_loss_r;

  logic trade_ready;
  logic s2_rdy;
  logic s1_rdy;
  logic accept;
  logic first;

  assign s2_rdy   = !s2_valid_r || trade_ready;
  assign s1_rdy   = !s1_valid_r || s2_rdy;
  assign in_stall = !s1_rdy;
  assign accept   = in_valid && s1_rdy;
  assign first    = (items_seen_r == '0);

  logic [WIN_W-1:0] win_eff;
  logic [CNT_W-1:0] win_cnt;

  always_comb begin
    if (window_len_r == '0) begin
      win_eff = WIN_W'(1);
    end else if (32'(window_len_r) > 32'(MAX_WINDOW)) begin
      win_eff = WIN_W'(MAX_WINDOW);
    end else begin
      win_eff = WIN_W'(window_len_r);
    end
    win_cnt = CNT_W'(win_eff);
  end

  // price change against the previous price
  logic                  chg_neg;
  logic [PRICE_BITS-1:0] chg_mag;
  logic [ENT_W-1:0]      chg_entry;
  logic [PTR_W-1:0]      ring_ptr_nxt;
  logic                  hist_we;

  assign chg_neg   = in_price < last_price_r;
  assign chg_mag   = chg_neg ? (last_price_r - in_price) : (in_price - last_price_r);
  assign chg_entry = {chg_neg, chg_mag};
  assign hist_we   = accept && !first;
  assign ring_ptr_nxt = ((WIN_W'(ring_ptr_r) + WIN_W'(1)) >= win_eff) ? '0
                                                                      : ring_ptr_r + 1'b1;

  // read the old entry and overwrite it in the same cycle
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[ring_ptr_r] <= chg_entry;
      hist_rd_r            <= hist_mem[ring_ptr_r];
    end
  end

  // add the new change and drop the oldest one once the window is full
  logic             old_neg;
  logic [SUM_W-1:0] old_mag;
  logic [SUM_W-1:0] new_mag;
  logic [SUM_W-1:0] gain_nxt;
  logic [SUM_W-1:0] loss_nxt;

  always_comb begin
    old_neg  = hist_rd_r[ENT_W-1];
    old_mag  = SUM_W'(hist_rd_r[PRICE_BITS-1:0]);
    new_mag  = SUM_W'(s1_mag_r);
    gain_nxt = gain_sum_r;
    loss_nxt = loss_sum_r;
    if (s1_sub_r) begin
      if (old_neg) begin
        loss_nxt = loss_nxt - old_mag;
      end else begin
        gain_nxt = gain_nxt - old_mag;
      end
    end
    if (s1_neg_r) begin
      loss_nxt = loss_nxt + new_mag;
    end else begin
      gain_nxt = gain_nxt + new_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r     <= WINDOW_LEN_RST;
      position_limit_r <= POSITION_LIMIT_RST;
      oversold_r       <= OVERSOLD_RST;
      overbought_r     <= OVERBOUGHT_RST;
      last_price_r     <= '0;
      items_seen_r     <= '0;
      ring_ptr_r       <= '0;
      gain_sum_r       <= '0;
      loss_sum_r       <= '0;
      s1_valid_r       <= 1'b0;
      s2_valid_r       <= 1'b0;
    end else begin
      if (accept) begin
        last_price_r <= in_price;
        if (first) begin
          items_seen_r <= CNT_W'(1);
        end else begin
          ring_ptr_r <= ring_ptr_nxt;
          if (items_seen_r <= win_cnt) begin
            items_seen_r <= items_seen_r + 1'b1;
          end
        end
      end
      if (s1_rdy) begin
        s1_valid_r <= hist_we;
        s1_emit_r  <= items_seen_r >= win_cnt;
        s1_sub_r   <= items_seen_r > win_cnt;
        s1_neg_r   <= chg_neg;
        s1_mag_r   <= chg_mag;
        s1_price_r <= in_price;
      end
      if (s2_rdy) begin
        s2_valid_r <= s1_valid_r && s1_emit_r;
        s2_price_r <= s1_price_r;
        s2_gain_r  <= gain_nxt;
        s2_loss_r  <= loss_nxt;
      end
      if (s1_valid_r && s2_rdy) begin
        gain_sum_r <= gain_nxt;
        loss_sum_r <= loss_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_LEN: begin
            window_len_r <= cfg_data[WINLEN_W-1:0];
            items_seen_r <= '0;
            ring_ptr_r   <= '0;
            gain_sum_r   <= '0;
            loss_sum_r   <= '0;
          end
          REG_POSITION_LIMIT: position_limit_r <= cfg_data[LIMIT_W-1:0];
          REG_OVERSOLD:       oversold_r       <= cfg_data[LEVEL_W-1:0];
          REG_OVERBOUGHT:     overbought_r     <= cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  rsitt_trade #(
    .PRICE_BITS (PRICE_BITS),
    .SUM_W      (SUM_W)
  ) u_trade (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (s2_valid_r),
    .req_ready         (trade_ready),
    .req_price         (s2_price_r),
    .req_gain          (s2_gain_r),
    .req_loss          (s2_loss_r),
    .position_limit    (position_limit_r),
    .oversold_level    (oversold_r),
    .overbought_level  (overbought_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_action        (out_action),
    .out_holding       (out_holding),
    .out_cash_balance  (out_cash_balance),
    .out_marked_profit (out_marked_profit)
  );

endmodule
